// ----- design/ktl_pkg.sv -----
// Package for the keyword token lexer: token kinds, error codes, scan modes,
// source byte constants, the keyword table and the byte classifier.
// No dependencies.
package ktl_pkg;

	// default for the top-level token length limit
	localparam int MaxTokenLenDef = 128;

	// result field widths
	localparam int KindW  = 5;
	localparam int ValueW = 31;
	localparam int LetW   = 5;

	// output queue depth: room for the two results one byte may cause, plus slack
	localparam int OutDepth = 4;

	typedef logic [KindW-1:0]  kind_t;
	typedef logic [ValueW-1:0] value_t;
	typedef logic [LetW-1:0]   let_t;

	// token kinds
	localparam kind_t K_EQL   = 5'd13;
	localparam kind_t K_NOT   = 5'd14;
	localparam kind_t K_LES   = 5'd15;
	localparam kind_t K_GRT   = 5'd16;
	localparam kind_t K_PLS   = 5'd17;
	localparam kind_t K_MIN   = 5'd18;
	localparam kind_t K_MUL   = 5'd19;
	localparam kind_t K_DIV   = 5'd20;
	localparam kind_t K_NLN   = 5'd21;
	localparam kind_t K_NUM   = 5'd22;
	localparam kind_t K_IDENT = 5'd23;
	localparam kind_t K_SCHR  = 5'd24;
	localparam kind_t K_SEND  = 5'd25;
	localparam kind_t K_TEXT  = 5'd26;
	localparam kind_t K_INPUT = 5'd27;
	localparam kind_t K_ERR   = 5'd28;

	// error codes carried in the value field of an error token
	localparam value_t E_HALTED  = 31'd0;
	localparam value_t E_BADCHAR = 31'd1;
	localparam value_t E_BADWORD = 31'd2;
	localparam value_t E_FLOAT   = 31'd3;
	localparam value_t E_TOOLONG = 31'd4;
	localparam value_t E_STRCHAR = 31'd5;
	localparam value_t E_UNCLOSED = 31'd6;

	localparam value_t NUM_MAX = 31'h7FFF_FFFF;

	// scan modes
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_WORD = 2'd1;
	localparam logic [1:0] MODE_NUM  = 2'd2;
	localparam logic [1:0] MODE_STR  = 2'd3;

	// source bytes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_EOI   = 8'hFF;

	// keyword table, letters as indexes a=0 .. z=25, unused tail is zero
	localparam int NKeys  = 13;
	localparam int MaxWord = 6;

	localparam logic [2:0] KW_LEN [NKeys] = '{
		3'd5, 3'd2, 3'd4, 3'd5, 3'd2, 3'd5, 3'd4, 3'd3, 3'd5, 3'd3, 3'd4, 3'd6, 3'd4
	};

	localparam let_t KW_CHR [NKeys][MaxWord] = '{
		'{5'd15, 5'd17, 5'd8,  5'd13, 5'd19, 5'd0 },  // print
		'{5'd8,  5'd5,  5'd0,  5'd0,  5'd0,  5'd0 },  // if
		'{5'd19, 5'd7,  5'd4,  5'd13, 5'd0,  5'd0 },  // then
		'{5'd22, 5'd7,  5'd8,  5'd11, 5'd4,  5'd0 },  // while
		'{5'd3,  5'd14, 5'd0,  5'd0,  5'd0,  5'd0 },  // do
		'{5'd11, 5'd0,  5'd1,  5'd4,  5'd11, 5'd0 },  // label
		'{5'd6,  5'd14, 5'd19, 5'd14, 5'd0,  5'd0 },  // goto
		'{5'd11, 5'd4,  5'd19, 5'd0,  5'd0,  5'd0 },  // let
		'{5'd8,  5'd13, 5'd15, 5'd20, 5'd19, 5'd0 },  // input
		'{5'd4,  5'd13, 5'd3,  5'd0,  5'd0,  5'd0 },  // end
		'{5'd15, 5'd17, 5'd14, 5'd2,  5'd0,  5'd0 },  // proc
		'{5'd17, 5'd4,  5'd19, 5'd20, 5'd17, 5'd13},  // return
		'{5'd2,  5'd0,  5'd11, 5'd11, 5'd0,  5'd0 }   // call
	};

	// what a byte does when it starts a token
	typedef struct packed {
		logic  skip;
		logic  emit;
		kind_t kind;
		logic  quote;
		logic  letter;
		logic  digit;
	} cls_t;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		r        = '0;
		r.letter = (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
		r.digit  = (c >= CH_ZERO && c <= CH_NINE);
		case (c)
			CH_SPACE, CH_TAB, CH_CR: r.skip = 1'b1;
			CH_NUL:   begin r.emit = 1'b1; r.kind = K_TEXT;  end
			CH_EOI:   begin r.emit = 1'b1; r.kind = K_INPUT; end
			CH_LF:    begin r.emit = 1'b1; r.kind = K_NLN;   end
			CH_PLUS:  begin r.emit = 1'b1; r.kind = K_PLS;   end
			CH_DASH:  begin r.emit = 1'b1; r.kind = K_MIN;   end
			CH_STAR:  begin r.emit = 1'b1; r.kind = K_MUL;   end
			CH_SLASH: begin r.emit = 1'b1; r.kind = K_DIV;   end
			CH_EQ:    begin r.emit = 1'b1; r.kind = K_EQL;   end
			CH_BANG:  begin r.emit = 1'b1; r.kind = K_NOT;   end
			CH_GT:    begin r.emit = 1'b1; r.kind = K_GRT;   end
			CH_LT:    begin r.emit = 1'b1; r.kind = K_LES;   end
			CH_QUOTE: r.quote = 1'b1;
			default:  r.skip = 1'b0;
		endcase
		return r;
	endfunction

	// case-folded letter index
	function automatic let_t fold(input logic [7:0] c);
		logic [7:0] t;
		t = (c | 8'h20) - CH_LA;
		return t[LetW-1:0];
	endfunction

endpackage

// ----- design/keyword_token_lexer.sv -----
// Keyword token lexer top level: input byte register, single-pass scanner
// logic and a small result queue. Depends on ktl_pkg.
//
// Usage:
//   Source bytes enter on the s_ channel, one byte per transfer (s_tdata).
//   Tokens leave on the m_ channel: m_tuser is the token kind, m_tdata the
//   value (number, letter index, string byte or error code), and m_tlast marks
//   the last token caused by one source byte. A byte may cause no token
//   (blank, or a letter/digit inside a run), one, or two (a word or number
//   ended by an operator or other one-byte token, or by a bad byte).
//   A token passes through the input byte register and then the result queue
//   before it shows on m_tvalid. Throughput: one byte per cycle while the
//   receiver keeps up; a byte that causes two tokens needs two output
//   transfers. The scanner takes a byte only when the 4-entry result queue
//   has room for two results, so a stalled receiver backs up into s_tready
//   and no token is lost.
//   Reset clears the scan mode, counters, the halt flag and the queue; the
//   block is ready right after reset. Any error halts the scanner, which then
//   answers every byte with an error token until the next reset.
module keyword_token_lexer #(
	parameter int MAX_TOKEN_LEN = ktl_pkg::MaxTokenLenDef
) (
	input  logic        clk,
	input  logic        arst_n,
	// source bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	// tokens
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [30:0] value, [31] zero fill
	output logic [4:0]  m_tuser,   // [4:0] kind
	output logic        m_tlast
);
	import ktl_pkg::*;

	localparam int TLW = $clog2(MAX_TOKEN_LEN);
	localparam logic [TLW-1:0] TOK_LIMIT = TLW'(MAX_TOKEN_LEN - 2);
	localparam int PW = $clog2(OutDepth);
	localparam int CW = $clog2(OutDepth + 1);

	// input register
	logic       valid_s1;
	logic [7:0] ch_s1;

	// scanner state
	logic [1:0]     mode_q;
	let_t           letters_q [MaxWord];
	logic [2:0]     wlen_q;
	value_t         num_q;
	logic [TLW-1:0] tok_q;
	logic           halt_q;

	// result queue
	kind_t          qkind_q [OutDepth];
	value_t         qval_q  [OutDepth];
	logic           qlast_q [OutDepth];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	// next-state and results of the scanner
	logic [1:0]     mode_d;
	logic [2:0]     wlen_d;
	value_t         num_d;
	logic [TLW-1:0] tok_d;
	logic           halt_d;
	logic           let_we;
	logic [2:0]     let_idx;
	let_t           let_val;
	kind_t          res_kind [2];
	value_t         res_val  [2];
	logic [1:0]     res_cnt;

	logic           consume, pop;
	cls_t           cls;
	logic           kw_hit;
	kind_t          kw_kind;
	logic [34:0]    num_ext;
	value_t         num_sat;

	assign pop      = m_tvalid && m_tready;
	assign consume  = valid_s1 && (cnt_q <= CW'(OutDepth - 2));
	assign s_tready = !valid_s1 || consume;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1 <= s_tdata;
		end
	end

	assign cls = classify(ch_s1);

	// keyword lookup on the collected letters, first match wins
	always_comb begin
		logic m;
		kw_hit  = 1'b0;
		kw_kind = '0;
		for (int k = NKeys - 1; k >= 0; k--) begin
			m = (wlen_q == KW_LEN[k]);
			for (int i = 0; i < MaxWord; i++) begin
				if (3'(i) < wlen_q && letters_q[i] != KW_CHR[k][i]) begin
					m = 1'b0;
				end
			end
			if (m) begin
				kw_hit  = 1'b1;
				kw_kind = KindW'(k);
			end
		end
	end

	// number times ten plus digit, saturating
	assign num_ext = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0} + {31'd0, ch_s1[3:0]};
	assign num_sat = (num_ext[34:31] != 4'd0) ? NUM_MAX : num_ext[30:0];

	// scanner: one byte in, up to two results out
	always_comb begin
		logic do_start;
		logic failed;
		mode_d   = mode_q;
		wlen_d   = wlen_q;
		num_d    = num_q;
		tok_d    = tok_q;
		halt_d   = halt_q;
		let_we   = 1'b0;
		let_idx  = wlen_q;
		let_val  = fold(ch_s1);
		res_kind = '{default: '0};
		res_val  = '{default: '0};
		res_cnt  = 2'd0;
		do_start = 1'b0;
		failed   = 1'b0;

		if (halt_q) begin
			res_kind[0] = K_ERR;
			res_val[0]  = E_HALTED;
			res_cnt     = 2'd1;
		end else begin
			case (mode_q)
				MODE_STR: begin
					if (ch_s1 == CH_QUOTE) begin
						mode_d      = MODE_IDLE;
						tok_d       = '0;
						res_kind[0] = K_SEND;
						res_cnt     = 2'd1;
					end else if (ch_s1 == CH_LF || ch_s1 == CH_TAB || ch_s1 == CH_CR ||
						ch_s1 == CH_BSL || ch_s1 == CH_PCT) begin
						failed     = 1'b1;
						res_val[0] = E_STRCHAR;
					end else if (ch_s1 == CH_NUL || ch_s1 == CH_EOI) begin
						failed     = 1'b1;
						res_val[0] = E_UNCLOSED;
					end else if (tok_q == TOK_LIMIT) begin
						failed     = 1'b1;
						res_val[0] = E_TOOLONG;
					end else begin
						tok_d       = tok_q + TLW'(1);
						res_kind[0] = K_SCHR;
						res_val[0]  = {23'd0, ch_s1};
						res_cnt     = 2'd1;
					end
				end
				MODE_WORD: begin
					if (cls.letter) begin
						let_we = (wlen_q < 3'd6);
						if (wlen_q < 3'd7) begin
							wlen_d = wlen_q + 3'd1;
						end
					end else begin
						mode_d = MODE_IDLE;
						wlen_d = 3'd0;
						if (wlen_q == 3'd1) begin
							res_kind[0] = K_IDENT;
							res_val[0]  = {26'd0, letters_q[0]};
							res_cnt     = 2'd1;
							do_start    = 1'b1;
						end else if (kw_hit) begin
							res_kind[0] = kw_kind;
							res_cnt     = 2'd1;
							do_start    = 1'b1;
						end else begin
							failed     = 1'b1;
							res_val[0] = E_BADWORD;
						end
					end
				end
				MODE_NUM: begin
					if (cls.digit) begin
						num_d = num_sat;
						tok_d = tok_q + TLW'(1);
						if (tok_q == TOK_LIMIT) begin
							failed     = 1'b1;
							res_val[0] = E_TOOLONG;
						end
					end else if (ch_s1 == CH_DOT) begin
						failed     = 1'b1;
						res_val[0] = E_FLOAT;
					end else begin
						res_kind[0] = K_NUM;
						res_val[0]  = num_q;
						res_cnt     = 2'd1;
						mode_d      = MODE_IDLE;
						num_d       = '0;
						tok_d       = '0;
						do_start    = 1'b1;
					end
				end
				default: begin
					do_start = 1'b1;
				end
			endcase

			// byte handled as the start of a token
			if (do_start) begin
				if (cls.skip) begin
					res_cnt = res_cnt;
				end else if (cls.emit) begin
					res_kind[res_cnt[0]] = cls.kind;
					res_val[res_cnt[0]]  = '0;
					res_cnt              = res_cnt + 2'd1;
				end else if (cls.quote) begin
					mode_d = MODE_STR;
					tok_d  = '0;
				end else if (cls.letter) begin
					mode_d  = MODE_WORD;
					let_we  = 1'b1;
					let_idx = 3'd0;
					wlen_d  = 3'd1;
				end else if (cls.digit) begin
					mode_d = MODE_NUM;
					num_d  = {27'd0, ch_s1[3:0]};
					tok_d  = TLW'(1);
				end else begin
					failed              = 1'b1;
					res_val[res_cnt[0]] = E_BADCHAR;
				end
			end

			// any error: halt and report, always as the final result
			if (failed) begin
				halt_d               = 1'b1;
				mode_d               = MODE_IDLE;
				wlen_d               = 3'd0;
				num_d                = '0;
				tok_d                = '0;
				let_we               = 1'b0;
				res_kind[res_cnt[0]] = K_ERR;
				res_cnt              = res_cnt + 2'd1;
			end
		end
	end

	// scanner state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			wlen_q <= 3'd0;
			num_q  <= '0;
			tok_q  <= '0;
			halt_q <= 1'b0;
		end else if (consume) begin
			mode_q <= mode_d;
			wlen_q <= wlen_d;
			num_q  <= num_d;
			tok_q  <= tok_d;
			halt_q <= halt_d;
		end
	end

	// word letters, written at the current word length while it is below six
	always_ff @(posedge clk) begin
		if (consume && let_we) begin
			letters_q[let_idx] <= let_val;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (consume) begin
			for (int i = 0; i < 2; i++) begin
				if (2'(i) < res_cnt) begin
					qkind_q[wr_ptr_q + PW'(i)] <= res_kind[i];
					qval_q[wr_ptr_q + PW'(i)]  <= res_val[i];
					qlast_q[wr_ptr_q + PW'(i)] <= (2'(i + 1) == res_cnt);
				end
			end
		end
	end

	// result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (consume) begin
				wr_ptr_q <= wr_ptr_q + PW'(res_cnt);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + (consume ? CW'(res_cnt) : CW'(0)) - (pop ? CW'(1) : CW'(0));
		end
	end

	// output channel
	assign m_tvalid = (cnt_q != '0);
	assign m_tuser  = qkind_q[rd_ptr_q];
	assign m_tdata  = {1'b0, qval_q[rd_ptr_q]};
	assign m_tlast  = qlast_q[rd_ptr_q];

endmodule
